// File: rtl/core/sio_cfs_pkg.sv
// types, constants and helper functions for the serial command frame sync
// used by every module of the block; depends on nothing else
package sio_cfs_pkg;

    localparam int BYTE_W       = 8;
    localparam int FRAME_BYTES  = 4;
    localparam int MAX_DEVICES  = 8;
    localparam int IDS_W        = MAX_DEVICES * BYTE_W;
    localparam int COUNT_W      = 4;
    localparam int FILL_W       = 3;
    localparam int WIN_IDX_W    = 2;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 64;
    localparam int FRAME_DATA_W = FRAME_BYTES * BYTE_W;

    localparam logic [BYTE_W-1:0]  FAST_ID_LO = 8'h50;
    localparam logic [BYTE_W-1:0]  FAST_ID_HI = 8'h53;
    localparam logic [FILL_W-1:0]  FILL_FULL  = 3'd4;

    // register indexes of the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ACTIVE_IDS   = 2'd0,
        CFG_ACTIVE_COUNT = 2'd1,
        CFG_FAST_PATH    = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic [IDS_W-1:0]   active_ids;
        logic [COUNT_W-1:0] active_count;
        logic               fast_path_enable;
    } cfg_t;

    typedef struct packed {
        logic [BYTE_W-1:0] aux_high;
        logic [BYTE_W-1:0] aux_low;
        logic [BYTE_W-1:0] command_code;
        logic [BYTE_W-1:0] device_id;
        logic              skip_delay;
    } frame_t;

    // one step of the end-around-carry sum
    function automatic logic [BYTE_W-1:0] eac_add(input logic [BYTE_W-1:0] a,
                                                  input logic [BYTE_W-1:0] b);
        logic [BYTE_W:0] s;
        begin
            s = {1'b0, a} + {1'b0, b};
            eac_add = s[BYTE_W-1:0] + {{(BYTE_W-1){1'b0}}, s[BYTE_W]};
        end
    endfunction

    // true when the id sits in one of the enabled slots
    function automatic logic id_active(input cfg_t cfg, input logic [BYTE_W-1:0] id);
        logic hit;
        begin
            hit = 1'b0;
            for (int k = 0; k < MAX_DEVICES; k++) begin
                if ((COUNT_W'(k) < cfg.active_count) &&
                    (cfg.active_ids[k*BYTE_W +: BYTE_W] == id)) begin
                    hit = 1'b1;
                end
            end
            id_active = hit;
        end
    endfunction

endpackage

// File: rtl/core/sio_cfs_cfg_regs.sv
// configuration registers: active ids, active count, fast path enable
// depends on sio_cfs_pkg
module sio_cfs_cfg_regs (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [sio_cfs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [sio_cfs_pkg::CFG_DATA_W-1:0] cfg_data,
    output sio_cfs_pkg::cfg_t                  cfg
);
    import sio_cfs_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    // register write decode
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                CFG_ACTIVE_IDS:   cfg_next.active_ids       = cfg_data[IDS_W-1:0];
                CFG_ACTIVE_COUNT: cfg_next.active_count     = cfg_data[COUNT_W-1:0];
                CFG_FAST_PATH:    cfg_next.fast_path_enable = cfg_data[0];
                default:          cfg_next                  = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// File: rtl/core/sio_cfs_window.sv
// byte window, fill count and frame check for each received byte
// depends on sio_cfs_pkg
module sio_cfs_window (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          byte_accept,
    input  logic [sio_cfs_pkg::BYTE_W-1:0] rx_byte,
    input  sio_cfs_pkg::cfg_t              cfg,
    output logic                          frame_hit,
    output sio_cfs_pkg::frame_t            frame
);
    import sio_cfs_pkg::*;

    logic [BYTE_W-1:0] win_reg  [FRAME_BYTES];
    logic [BYTE_W-1:0] win_next [FRAME_BYTES];
    logic [FILL_W-1:0] fill_reg;
    logic [FILL_W-1:0] fill_next;
    logic [BYTE_W-1:0] sum;
    logic              full;

    assign full = (fill_reg == FILL_FULL);

    // end-around-carry sum of the four stored bytes
    always_comb begin
        sum = '0;
        for (int i = 0; i < FRAME_BYTES; i++) begin
            sum = eac_add(sum, win_reg[i]);
        end
    end

    assign frame_hit = byte_accept && full && id_active(cfg, win_reg[0]) && (sum == rx_byte);

    // frame fields as they leave on a hit
    always_comb begin
        frame.device_id    = win_reg[0];
        frame.command_code = win_reg[1];
        frame.aux_low      = win_reg[2];
        frame.aux_high     = win_reg[3];
        frame.skip_delay   = cfg.fast_path_enable &&
                             (win_reg[0] >= FAST_ID_LO) && (win_reg[0] <= FAST_ID_HI);
    end

    // window update: fill, clear on a frame, else slide
    always_comb begin
        win_next  = win_reg;
        fill_next = fill_reg;
        if (byte_accept) begin
            if (!full) begin
                win_next[fill_reg[WIN_IDX_W-1:0]] = rx_byte;
                fill_next = fill_reg + FILL_W'(1);
            end else if (frame_hit) begin
                for (int i = 0; i < FRAME_BYTES; i++) begin
                    win_next[i] = '0;
                end
                fill_next = '0;
            end else begin
                for (int i = 0; i < FRAME_BYTES - 1; i++) begin
                    win_next[i] = win_reg[i+1];
                end
                win_next[FRAME_BYTES-1] = rx_byte;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg <= '0;
            for (int i = 0; i < FRAME_BYTES; i++) begin
                win_reg[i] <= '0;
            end
        end else begin
            fill_reg <= fill_next;
            win_reg  <= win_next;
        end
    end

endmodule

// File: rtl/core/sio_cfs_out_reg.sv
// result register holding one frame until the downstream side takes it
// depends on sio_cfs_pkg
module sio_cfs_out_reg (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               load,
    input  sio_cfs_pkg::frame_t frame_in,
    output logic               space,
    output logic               m_tvalid,
    input  logic               m_tready,
    output sio_cfs_pkg::frame_t frame_out
);
    import sio_cfs_pkg::*;

    logic   valid_reg;
    logic   valid_next;
    frame_t frame_reg;

    // room for a new result when empty or draining this cycle
    assign space     = !valid_reg || m_tready;
    assign m_tvalid  = valid_reg;
    assign frame_out = frame_reg;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // payload needs no reset
    always_ff @(posedge aclk) begin
        if (load) begin
            frame_reg <= frame_in;
        end
    end

endmodule

// File: rtl/core/sio_command_frame_sync_unit.sv
// serial command frame sync: one received byte per request, one frame out per match
// a frame appears on m_ in the cycle after the request carrying its check byte
// throughput: one byte per cycle; the input stalls only while a result waits unread
// reset (aresetn low, synchronous): window and fill count cleared, output empty,
// configuration registers cleared
module sio_command_frame_sync_unit (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [7:0]                        s_tdata,   // rx_byte[7:0]
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [31:0]                       m_tdata,   // device_id, command_code,
                                                          // aux_low, aux_high
    output logic [0:0]                        m_tuser,   // skip_delay
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [sio_cfs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [sio_cfs_pkg::CFG_DATA_W-1:0] cfg_data
);
    import sio_cfs_pkg::*;

    cfg_t   cfg;
    frame_t frame;
    frame_t frame_out;
    logic   frame_hit;
    logic   space;
    logic   byte_accept;

    assign s_tready    = space;
    assign byte_accept = s_tvalid && space;

    sio_cfs_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    sio_cfs_window u_win (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .byte_accept (byte_accept),
        .rx_byte     (s_tdata),
        .cfg         (cfg),
        .frame_hit   (frame_hit),
        .frame       (frame)
    );

    sio_cfs_out_reg u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (frame_hit),
        .frame_in  (frame),
        .space     (space),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .frame_out (frame_out)
    );

    // pack result fields, first field lowest
    assign m_tdata = {frame_out.aux_high, frame_out.aux_low,
                      frame_out.command_code, frame_out.device_id};
    assign m_tuser = frame_out.skip_delay;

endmodule

// File: rtl/core/sio_cfs_checker.sv
// port-level checks for the serial command frame sync, bound to the top level
// depends on sio_cfs_pkg and sio_command_frame_sync_unit
module sio_cfs_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic [0:0]  m_tuser
);
    import sio_cfs_pkg::*;

    // a stalled result holds its payload
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // output is empty right after reset
    a_reset: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // a new result only follows an accepted byte
    a_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready))
        else $error("result without a request");

    // skip_delay only for ids in the fast range
    a_skip: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> (m_tdata[7:0] >= FAST_ID_LO) && (m_tdata[7:0] <= FAST_ID_HI))
        else $error("skip_delay set outside fast id range");

endmodule

bind sio_command_frame_sync_unit sio_cfs_checker u_sio_cfs_checker (.*);

// File: bench/sio_command_frame_sync_unit_tb.sv
// self-checking bench for the serial command frame sync unit
// depends on sio_cfs_pkg and sio_command_frame_sync_unit; predicts frames in a small class
`timescale 1ns / 1ps

module sio_command_frame_sync_unit_tb;
    import sio_cfs_pkg::*;

    localparam int LIMIT_CYCLES  = 400000;
    localparam int PHASES        = 8;
    localparam int PHASE_BYTES   = 212;
    localparam int MAX_REPORTS   = 10;

    // frame predictor: sliding byte window, register copy, queue of expected frames
    class frame_predictor;
        logic [IDS_W-1:0]   active_ids;
        logic [COUNT_W-1:0] active_count;
        logic               fast_path;
        logic [BYTE_W-1:0]  window [FRAME_BYTES];
        int                 fill;
        frame_t             expected_frames [$];
        int                 mismatches;

        function new();
            active_ids   = '0;
            active_count = '0;
            fast_path    = 1'b0;
            fill         = 0;
            mismatches   = 0;
            foreach (window[i]) window[i] = '0;
        endfunction

        // end-around-carry sum of four bytes
        static function logic [BYTE_W-1:0] eac_sum(input logic [BYTE_W-1:0] b0,
                                                   input logic [BYTE_W-1:0] b1,
                                                   input logic [BYTE_W-1:0] b2,
                                                   input logic [BYTE_W-1:0] b3);
            int unsigned s;
            logic [BYTE_W-1:0] b [FRAME_BYTES];
            b[0] = b0; b[1] = b1; b[2] = b2; b[3] = b3;
            s = 0;
            foreach (b[i]) begin
                s = s + b[i];
                if (s > 255) s = s - 255;
            end
            return s[BYTE_W-1:0];
        endfunction

        function bit id_enabled(input logic [BYTE_W-1:0] id);
            int n;
            n = (active_count > MAX_DEVICES) ? MAX_DEVICES : active_count;
            for (int k = 0; k < n; k++) begin
                if (active_ids[k*BYTE_W +: BYTE_W] == id) return 1'b1;
            end
            return 1'b0;
        endfunction

        function void set_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_ACTIVE_IDS:   active_ids   = data[IDS_W-1:0];
                CFG_ACTIVE_COUNT: active_count = data[COUNT_W-1:0];
                CFG_FAST_PATH:    fast_path    = data[0];
                default: ;
            endcase
        endfunction

        // one accepted byte request
        function void note_byte(input logic [BYTE_W-1:0] b);
            frame_t f;
            if (fill < FRAME_BYTES) begin
                window[fill] = b;
                fill++;
            end else if (id_enabled(window[0]) &&
                         eac_sum(window[0], window[1], window[2], window[3]) == b) begin
                f.device_id    = window[0];
                f.command_code = window[1];
                f.aux_low      = window[2];
                f.aux_high     = window[3];
                f.skip_delay   = fast_path && window[0] >= FAST_ID_LO &&
                                 window[0] <= FAST_ID_HI;
                expected_frames.push_back(f);
                foreach (window[i]) window[i] = '0;
                fill = 0;
            end else begin
                for (int i = 0; i < FRAME_BYTES - 1; i++) window[i] = window[i+1];
                window[FRAME_BYTES-1] = b;
            end
        endfunction

        function void note_error(input string what);
            mismatches++;
            if (mismatches <= MAX_REPORTS) $display("%t: %s", $realtime, what);
        endfunction

        // one accepted frame on the output
        function void check_frame(input logic [31:0] data, input logic [0:0] user);
            frame_t f;
            if (expected_frames.size() == 0) begin
                note_error($sformatf("unexpected frame data=%h skip=%b", data, user));
                return;
            end
            f = expected_frames.pop_front();
            if (data[7:0] !== f.device_id || data[15:8] !== f.command_code ||
                data[23:16] !== f.aux_low || data[31:24] !== f.aux_high ||
                user[0] !== f.skip_delay) begin
                note_error($sformatf(
                    "frame mismatch exp id=%h cmd=%h lo=%h hi=%h skip=%b, got %h %h %h %h %b",
                    f.device_id, f.command_code, f.aux_low, f.aux_high, f.skip_delay,
                    data[7:0], data[15:8], data[23:16], data[31:24], user[0]));
            end
        endfunction
    endclass

    logic                   aclk;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [7:0]             s_tdata;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [31:0]            m_tdata;
    logic [0:0]             m_tuser;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    frame_predictor pred = new();
    int  cycles;
    bit  tx_steady;
    bit  rx_steady;

    sio_command_frame_sync_unit DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),     // rx_byte[7:0]
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),     // device_id, command_code, aux_low, aux_high
        .m_tuser   (m_tuser),     // skip_delay
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // clock
    initial aclk = 1'b0;
    always #2 aclk = ~aclk;

    // run limit
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == LIMIT_CYCLES) begin
            $display("sio_command_frame_sync_unit_tb: errors");
            $finish;
        end
    end

    // result side: random stalls, check every accepted frame
    initial begin
        int stall;
        m_tready = 1'b0;
        wait (aresetn === 1'b1);
        @(negedge aclk);
        forever begin
            stall = rx_steady ? 0 : $urandom_range(0, 3);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (m_tvalid !== 1'b1);
            pred.check_frame(m_tdata, m_tuser);
            @(negedge aclk);
        end
    end

    // one byte request, with a random gap in front
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = tx_steady ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge aclk); while (s_tready !== 1'b1);
        pred.note_byte(b);
        @(negedge aclk);
    endtask

    // five bytes: id, command, aux pair, check byte (optionally broken)
    task automatic send_frame(input logic [7:0] id, input logic [7:0] cmd,
                              input logic [7:0] lo, input logic [7:0] hi,
                              input bit broken);
        logic [7:0] chk;
        chk = frame_predictor::eac_sum(id, cmd, lo, hi);
        if (broken) chk = chk + 8'($urandom_range(1, 255));
        send_byte(id);
        send_byte(cmd);
        send_byte(lo);
        send_byte(hi);
        send_byte(chk);
    endtask

    // hold input until every expected frame is out, then let the pipe settle
    task automatic drain;
        s_tvalid <= 1'b0;
        while (pred.expected_frames.size() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (cfg_ready !== 1'b1);
        pred.set_reg(idx, data);
        @(negedge aclk);
    endtask

    // all three registers; upper data bits random where the register ignores them
    task automatic write_regs(input logic [63:0] ids, input logic [3:0] count,
                              input logic fast);
        logic [63:0] junk;
        junk = {$urandom, $urandom};
        write_reg(CFG_ACTIVE_IDS, ids);
        write_reg(CFG_ACTIVE_COUNT, {junk[63:4], count});
        write_reg(CFG_FAST_PATH, {junk[63:1], fast});
        cfg_valid <= 1'b0;
    endtask

    // device id for a well-formed frame: mostly from an enabled slot
    function automatic logic [7:0] pick_id();
        int n;
        n = (pred.active_count > MAX_DEVICES) ? MAX_DEVICES : pred.active_count;
        if (n > 0 && $urandom_range(0, 3) != 0)
            return pred.active_ids[$urandom_range(0, n - 1)*BYTE_W +: BYTE_W];
        if ($urandom_range(0, 1) == 0)
            return 8'($urandom_range(FAST_ID_LO, FAST_ID_HI));
        return 8'($urandom_range(0, 255));
    endfunction

    // random ids with some ids in or just outside the fast-path range mixed in
    function automatic logic [63:0] random_ids();
        logic [63:0] ids;
        ids = {$urandom, $urandom};
        for (int k = 0; k < MAX_DEVICES; k++) begin
            if ($urandom_range(0, 2) == 0)
                ids[k*BYTE_W +: BYTE_W] = 8'($urandom_range(FAST_ID_LO - 1, FAST_ID_HI + 1));
        end
        return ids;
    endfunction

    initial begin
        int sent;
        int pick;
        int hold_at;
        logic [63:0] ids;
        logic [3:0]  count;
        logic        fast;

        cycles    = 0;
        tx_steady = 1'b0;
        rx_steady = 1'b0;
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_ACTIVE_IDS;
        cfg_data  = '0;
        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed: wrap-around sum, all-ones, top slot, fast-path edges, bad check
        write_regs(64'h1250_544F_FF00_5350, 4'd8, 1'b1);
        send_frame(8'h50, 8'h00, 8'h01, 8'hFF, 1'b0);
        send_frame(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0);
        send_frame(8'h12, 8'hAA, 8'h55, 8'hC3, 1'b0);
        send_frame(8'h54, 8'h01, 8'h02, 8'h03, 1'b1);
        send_byte(8'h53);
        send_byte(8'h80);
        drain();
        // count above the slot limit, fast path off, window contents kept across the write
        write_regs(64'h1250_544F_FF00_5350, 4'd15, 1'b0);
        send_frame(8'h53, 8'h80, 8'h80, 8'h7F, 1'b0);
        drain();
        // no active slots: no frame is matched
        write_regs(64'h1250_544F_FF00_5350, 4'd0, 1'b1);
        send_frame(8'h50, 8'h11, 8'h22, 8'h33, 1'b0);
        drain();

        // random phases, each with its own register setting
        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: begin ids = random_ids(); count = 4'd8;  fast = 1'b1; end
                1: begin ids = '1;           count = 4'd15; fast = 1'b1; end
                2: begin ids = random_ids(); count = 4'd0;  fast = 1'b0; end
                3: begin ids = '0;           count = 4'd1;  fast = 1'b0; end
                default: begin
                    ids   = random_ids();
                    count = 4'($urandom_range(0, 15));
                    fast  = 1'($urandom_range(0, 1));
                end
            endcase
            write_regs(ids, count, fast);
            tx_steady = ($urandom_range(0, 3) == 0);
            rx_steady = ($urandom_range(0, 3) == 0);
            hold_at   = $urandom_range(PHASE_BYTES / 4, 3 * PHASE_BYTES / 4);
            sent = 0;
            while (sent < PHASE_BYTES) begin
                pick = $urandom_range(0, 9);
                if (pick <= 6) begin
                    send_frame(pick_id(), 8'($urandom), 8'($urandom), 8'($urandom), 1'b0);
                    sent += 5;
                end else if (pick == 7) begin
                    send_frame(pick_id(), 8'($urandom), 8'($urandom), 8'($urandom), 1'b1);
                    sent += 5;
                end else if (pick == 8) begin
                    repeat ($urandom_range(1, 3)) begin
                        send_byte(8'($urandom));
                        sent++;
                    end
                end else begin
                    send_frame(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 1'b0);
                    sent += 5;
                end
                // sender holds off until the output has caught up
                if (sent >= hold_at && hold_at > 0) begin
                    drain();
                    hold_at = 0;
                end
            end
            drain();
        end

        rx_steady = 1'b0;
        drain();
        repeat (8) @(negedge aclk);
        if (pred.expected_frames.size() != 0) pred.note_error("frames still expected at end");
        if (pred.mismatches == 0) begin
            $display("sio_command_frame_sync_unit_tb: clean");
        end else begin
            $display("sio_command_frame_sync_unit_tb: errors");
        end
        $finish;
    end

endmodule
